[hdl/sort_then_halving_step_search_core_macros.svh]
// Assertion helpers used by the RTL file stsc_ctrl.sv.
`ifndef SORT_THEN_HALVING_STEP_SEARCH_CORE_MACROS_SVH
`define SORT_THEN_HALVING_STEP_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STSC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/stsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stsc_pkg;

    localparam int ENTRIES = 64;
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int VAL_W   = 16;
    localparam int POS_W   = 6;
    localparam int STEP_W  = 7;
    localparam int SHIFT_W = STEP_W + 1;

    localparam logic [STEP_W-1:0] STEP_MAX  = 7'd127;
    localparam logic [STEP_W-1:0] STEP_INIT = 7'd1;
    localparam logic [VAL_W-1:0]  KEY_RESET = 16'd850;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_I,
        S_SORT_BASE,
        S_SORT_SCAN,
        S_SORT_SWAP,
        S_SORT_SWAP2,
        S_SRCH_RD,
        S_SRCH_CUR,
        S_SRCH_NB,
        S_DONE
    } stsc_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } stsc_ram_req_t;

    typedef struct packed {
        logic              found;
        logic [POS_W-1:0]  pos;
        logic [STEP_W-1:0] step;
    } stsc_result_t;

endpackage

`default_nettype wire

[hdl/stsc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module stsc_ram
    import stsc_pkg::*;
(
    input  wire logic          aclk,
    input  wire stsc_ram_req_t req,
    output logic [VAL_W-1:0]   rdata
);

    logic [VAL_W-1:0] mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

[hdl/stsc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "sort_then_halving_step_search_core_macros.svh"

module stsc_ctrl
    import stsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [VAL_W-1:0] s_tdata,
    input  wire logic             s_tlast,
    input  wire logic [VAL_W-1:0] search_key,
    output stsc_ram_req_t         ram_req,
    input  wire logic [VAL_W-1:0] ram_rdata,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output stsc_result_t          res
);

    stsc_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [ADDR_W-1:0]  midx_reg, midx_next;
    logic [VAL_W-1:0]   min_reg, min_next;
    logic [VAL_W-1:0]   base_reg, base_next;
    logic [VAL_W-1:0]   cur_reg, cur_next;
    logic [ADDR_W-1:0]  p_reg, p_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               found_reg, found_next;

    logic [STEP_W-1:0]  step_sat;
    logic [SHIFT_W-1:0] shift_amt;
    logic [CNT_W-1:0]   move_raw, move_len, room;
    logic [ADDR_W-1:0]  p_moved;
    logic               between;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        midx_reg  <= midx_next;
        min_reg   <= min_next;
        base_reg  <= base_next;
        cur_reg   <= cur_next;
        p_reg     <= p_next;
        step_reg  <= step_next;
        found_reg <= found_next;
    end

    always_comb begin
        step_sat  = (step_reg == STEP_MAX) ? STEP_MAX : step_reg + STEP_INIT;
        shift_amt = SHIFT_W'(step_reg) + SHIFT_W'(1);
        move_raw  = n_reg >> shift_amt;
        move_len  = (move_raw == '0) ? CNT_W'(1) : move_raw;
        room      = n_reg - CNT_W'(1) - CNT_W'(p_reg);
        if (cur_reg < search_key) begin
            between = ram_rdata > search_key;
            p_moved = (move_len >= room) ? ADDR_W'(n_reg - CNT_W'(1))
                                         : ADDR_W'(CNT_W'(p_reg) + move_len);
        end else begin
            between = ram_rdata < search_key;
            p_moved = (move_len >= CNT_W'(p_reg)) ? '0 : p_reg - move_len[ADDR_W-1:0];
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        midx_next     = midx_reg;
        min_next      = min_reg;
        base_next     = base_reg;
        cur_next      = cur_reg;
        p_next        = p_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        ram_req       = '0;
        ram_req.raddr = p_reg;
        s_tready      = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (count_reg != CNT_W'(ENTRIES)) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = count_reg[ADDR_W-1:0];
                        ram_req.wdata = s_tdata;
                        count_next    = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        n_next     = count_next;
                        count_next = '0;
                        i_next     = '0;
                        found_next = 1'b0;
                        state_next = S_SORT_I;
                    end
                end
            end
            S_SORT_I: begin
                if (CNT_W'(i_reg) + CNT_W'(1) >= n_reg) begin
                    p_next     = n_reg[CNT_W-1:1];
                    step_next  = STEP_INIT;
                    state_next = S_SRCH_RD;
                end else begin
                    ram_req.raddr = i_reg;
                    state_next    = S_SORT_BASE;
                end
            end
            S_SORT_BASE: begin
                base_next     = ram_rdata;
                min_next      = ram_rdata;
                midx_next     = i_reg;
                ram_req.raddr = i_reg + ADDR_W'(1);
                j_next        = i_reg + ADDR_W'(1);
                state_next    = S_SORT_SCAN;
            end
            S_SORT_SCAN: begin
                if (ram_rdata < min_reg) begin
                    min_next  = ram_rdata;
                    midx_next = j_reg;
                end
                if (CNT_W'(j_reg) + CNT_W'(1) < n_reg) begin
                    ram_req.raddr = j_reg + ADDR_W'(1);
                    j_next        = j_reg + ADDR_W'(1);
                end else begin
                    state_next = S_SORT_SWAP;
                end
            end
            S_SORT_SWAP: begin
                if (midx_reg != i_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = i_reg;
                    ram_req.wdata = min_reg;
                    state_next    = S_SORT_SWAP2;
                end else begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = S_SORT_I;
                end
            end
            S_SORT_SWAP2: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = midx_reg;
                ram_req.wdata = base_reg;
                i_next        = i_reg + ADDR_W'(1);
                state_next    = S_SORT_I;
            end
            S_SRCH_RD: begin
                ram_req.raddr = p_reg;
                state_next    = S_SRCH_CUR;
            end
            S_SRCH_CUR: begin
                cur_next = ram_rdata;
                if (ram_rdata == search_key) begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end else if (ram_rdata < search_key) begin
                    if (CNT_W'(p_reg) + CNT_W'(1) >= n_reg) begin
                        step_next  = step_sat;
                        state_next = S_DONE;
                    end else begin
                        ram_req.raddr = p_reg + ADDR_W'(1);
                        state_next    = S_SRCH_NB;
                    end
                end else begin
                    if (p_reg == '0) begin
                        step_next  = step_sat;
                        state_next = S_DONE;
                    end else begin
                        ram_req.raddr = p_reg - ADDR_W'(1);
                        state_next    = S_SRCH_NB;
                    end
                end
            end
            S_SRCH_NB: begin
                step_next = step_sat;
                if (between) begin
                    state_next = S_DONE;
                end else begin
                    p_next     = p_moved;
                    state_next = S_SRCH_RD;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign res.found = found_reg;
    assign res.pos   = POS_W'(p_reg);
    assign res.step  = step_reg;

    `STSC_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(ENTRIES),
        "fill count overran table")
    `STSC_ASSERT_IMPL(a_pos_in_table, state_reg == S_SRCH_RD, CNT_W'(p_reg) < n_reg,
        "search position outside table")
    `STSC_ASSERT_IMPL(a_swap_order, state_reg == S_SORT_SWAP2,
        $past(state_reg) == S_SORT_SWAP && midx_reg != i_reg,
        "second swap write out of order")
    `STSC_ASSERT_NEXT(a_result_hold, state_reg == S_DONE && !res_ready,
        state_reg == S_DONE && $stable(p_reg) && $stable(step_reg) && $stable(found_reg),
        "result changed while stalled")

endmodule

`default_nettype wire

[hdl/sort_then_halving_step_search_core.sv]
// Sort-then-search core.
// s_ channel: one shelf value per transfer in s_tdata, s_tlast on the final value.
// Values fill a 64-entry table from index 0; values beyond 64 are dropped.
// After the transfer with s_tlast the table of n entries is sorted ascending by
// selection sort and then searched for the key held in the configuration
// register (cfg_valid/cfg_ready/cfg_data). The sort scans through the single
// read port of the table memory; each search step then reads the current entry
// and, unless it matches or lies at the table's end, its neighbour.
// s_tready is low during sort and search.
// m_ channel: one transfer per run: found in m_tuser, stop position and step
// count in m_tdata. The result sits in an output register; a new run may load
// while it waits, but the next run's result holds until the receiver takes it.
// Reset (aresetn low, synchronous) empties the table count, drops a pending
// result and sets the key to 850. Configure only while the core is idle.
`timescale 1ns / 1ps
`default_nettype none

module sort_then_halving_step_search_core
    import stsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,   // [15:0] entry_value
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [15:0]           m_tdata,   // [5:0] stop_position, [12:6] step_count
    output logic                  m_tuser,   // [0] found
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [VAL_W-1:0] cfg_data
);

    logic [VAL_W-1:0] key_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [15:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    stsc_ram_req_t    ram_req;
    logic [VAL_W-1:0] ram_rdata;
    logic             res_valid, res_ready;
    stsc_result_t     res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= KEY_RESET;
        end else if (cfg_valid) begin
            key_reg <= cfg_data;
        end
    end

    stsc_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    stsc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .search_key (key_reg),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {3'b000, res.step, res.pos};
            m_tuser_next  = res.found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[tb/sv/stsc_result_checker.sv]
`timescale 1ns / 1ps

module stsc_result_checker
    import stsc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [15:0]      s_tdata,   // [15:0] entry_value
    input  wire logic             s_tlast,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [15:0]      m_tdata,   // [5:0] stop_position, [12:6] step_count
    input  wire logic             m_tuser,   // [0] found
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [VAL_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    results_owed
);

    typedef logic [VAL_W-1:0] shelf_q_t[$];

    logic [VAL_W-1:0] search_key = KEY_RESET;
    shelf_q_t         shelf_q;
    stsc_result_t     owed_q[$];

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    function automatic stsc_result_t search_sorted_shelf(input shelf_q_t vals,
                                                         input logic [VAL_W-1:0] key);
        shelf_q_t     tbl;
        int           n;
        int           p;
        int           step;
        int           d;
        bit           hit;
        bit           settled;
        stsc_result_t r;
        tbl = vals;
        tbl.sort();
        n    = tbl.size();
        p    = n / 2;
        step = 1;
        hit  = 1'b0;
        for (int iter = 0; iter < 2 * ENTRIES + 64; iter++) begin
            if (tbl[p] == key) begin
                hit = 1'b1;
                break;
            end
            settled = (tbl[p] < key && p + 1 < n && tbl[p+1] > key)
                   || (tbl[p] > key && p > 0 && tbl[p-1] < key)
                   || (tbl[p] < key && p + 1 >= n)
                   || (tbl[p] > key && p == 0);
            if (settled) begin
                step++;
                break;
            end
            d = (step + 1 >= 32) ? 0 : (n >> (step + 1));
            if (d == 0)
                d = 1;
            if (tbl[p] < key)
                p = (d >= n - 1 - p) ? n - 1 : p + d;
            else
                p = (d >= p) ? 0 : p - d;
            step++;
        end
        r.found = hit;
        r.pos   = POS_W'(p);
        r.step  = (step > 127) ? STEP_MAX : STEP_W'(step);
        return r;
    endfunction

    always @(posedge aclk) begin
        stsc_result_t exp_r;
        if (!aresetn) begin
            search_key = KEY_RESET;
            shelf_q.delete();
            owed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                search_key = cfg_data;
            if (s_tvalid && s_tready) begin
                if (shelf_q.size() < ENTRIES)
                    shelf_q.push_back(s_tdata);
                if (s_tlast) begin
                    owed_q.push_back(search_sorted_shelf(shelf_q, search_key));
                    shelf_q.delete();
                end
            end
            if (m_tvalid && m_tready) begin
                if (owed_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got found %0d pos %0d step %0d",
                             $time, m_tuser, m_tdata[5:0], m_tdata[12:6]);
                end else begin
                    exp_r = owed_q.pop_front();
                    if (m_tuser !== exp_r.found) begin
                        mismatch_count++;
                        $display("%0t: found expected %0d got %0d", $time, exp_r.found, m_tuser);
                    end
                    if (m_tdata[5:0] !== exp_r.pos) begin
                        mismatch_count++;
                        $display("%0t: stop_position expected %0d got %0d",
                                 $time, exp_r.pos, m_tdata[5:0]);
                    end
                    if (m_tdata[12:6] !== exp_r.step) begin
                        mismatch_count++;
                        $display("%0t: step_count expected %0d got %0d",
                                 $time, exp_r.step, m_tdata[12:6]);
                    end
                end
            end
        end
        results_owed <= owed_q.size();
    end

endmodule

[tb/sv/sort_then_halving_step_search_core_tb.sv]
`timescale 1ns / 1ps

module sort_then_halving_step_search_core_tb;
    import stsc_pkg::*;

    typedef logic [VAL_W-1:0] shelf_q_t[$];

    localparam int PACE_FREE   = 0;
    localparam int PACE_SENDER = 1;
    localparam int PACE_RECV   = 2;
    localparam int PACE_BOTH   = 3;
    localparam int HOLD_CYCLES = 3000;
    localparam int ITEM_TARGET = 1450;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic [15:0]      s_tdata   = '0;
    logic             s_tlast   = 1'b0;
    logic             m_tready  = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [VAL_W-1:0] cfg_data  = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic        m_tuser;
    wire logic        cfg_ready;

    int               mismatches;
    int               owed;
    int               pace        = PACE_FREE;
    int               hold_req    = 0;
    int               hold_seen   = 0;
    int               hold_left   = 0;
    int               entries_sent = 0;
    logic [VAL_W-1:0] key_now     = KEY_RESET;

    sort_then_halving_step_search_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    stsc_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .results_owed   (owed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("sort_then_halving_step_search_core_tb failed");
        $finish;
    end

    // hold off the receiver for a long stretch on request, else pace m_tready by the pace mode
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (pace)
                PACE_RECV: m_tready <= ($urandom_range(99) >= 72);
                PACE_BOTH: m_tready <= ($urandom_range(99) >= 27);
                default:   m_tready <= 1'b1;
            endcase
        end
    end

    task automatic push_entry(input logic [VAL_W-1:0] v, input logic last);
        int idle_pct;
        idle_pct = (pace == PACE_SENDER) ? 72 : (pace == PACE_BOTH) ? 27 : 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        entries_sent++;
    endtask

    task automatic send_run(input shelf_q_t vals);
        for (int i = 0; i < vals.size(); i++)
            push_entry(vals[i], i == vals.size() - 1);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_key(input logic [VAL_W-1:0] k);
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_now = k;
    endtask

    function automatic logic [VAL_W-1:0] near_key(input int offset);
        int v;
        v = int'(key_now) + offset;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return VAL_W'(v);
    endfunction

    task automatic random_run(input int len);
        shelf_q_t vals;
        int       style;
        style = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
            case (style)
                0: vals.push_back(near_key(int'($urandom_range(40)) - 20));
                1: vals.push_back(VAL_W'($urandom_range(65535)));
                default: begin
                    case ($urandom_range(4))
                        0: vals.push_back(near_key(0));
                        1: vals.push_back(near_key(-1));
                        2: vals.push_back(near_key(1));
                        3: vals.push_back(16'h0000);
                        default: vals.push_back(16'hFFFF);
                    endcase
                end
            endcase
        end
        send_run(vals);
    endtask

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 80)
            return $urandom_range(1, 8);
        if (sel < 95)
            return $urandom_range(9, 24);
        if (sel < 99)
            return $urandom_range(33, 64);
        return $urandom_range(65, 70);
    endfunction

    initial begin
        int phase_start;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_run('{16'd850});
        send_run('{16'd0});
        send_run('{16'hFFFF});
        send_run('{16'd900, 16'd100, 16'd850, 16'd5000, 16'd0});
        send_run('{16'd100, 16'd200, 16'd900, 16'd1000});
        send_run('{16'd1, 16'd2, 16'd3, 16'd4, 16'd5});
        send_run('{16'd60000, 16'hFFFF, 16'd1000});
        drain_results();
        write_key(16'h0000);
        send_run('{16'd0, 16'hFFFF, 16'd0, 16'd12345});
        drain_results();
        write_key(16'hFFFF);
        send_run('{16'hFFFF, 16'hFFFF, 16'd0, 16'd1});
        drain_results();

        for (int ph = 0; entries_sent < ITEM_TARGET; ph++) begin
            drain_results();
            case (ph % 5)
                0: write_key(VAL_W'($urandom_range(65535)));
                1: write_key(16'h0000);
                2: write_key(16'hFFFF);
                3: write_key(VAL_W'($urandom_range(3000)));
                default: write_key(KEY_RESET);
            endcase
            pace <= ph % 4;
            @(posedge aclk);
            if (ph == 0)
                random_run(68);
            if (ph == 2) begin
                pace     <= PACE_FREE;
                hold_req <= hold_req + 1;
                for (int r = 0; r < 15; r++)
                    random_run($urandom_range(1, 4));
                drain_results();
                pace <= ph % 4;
            end
            phase_start = entries_sent;
            while (entries_sent - phase_start < 120 && entries_sent < ITEM_TARGET)
                random_run(pick_length());
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("sort_then_halving_step_search_core_tb passed");
        else
            $display("sort_then_halving_step_search_core_tb failed");
        $finish;
    end

endmodule
